// ===== src/rbc_pkg.sv =====
// Shared constants and helpers for the 2D barycentric core.
package rbc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int QUOT_BITS   = 34;
   localparam int Q_WIDTH     = QUOT_BITS + 2;
   localparam int THR_WIDTH   = 48;
   localparam int CLIP_BITS   = FRAC_BITS + 1;
   localparam int SUM_BITS    = FRAC_BITS + 2;

   localparam logic [THR_WIDTH-1:0]     THR_RESET  = 48'd168;
   localparam logic signed [Q_WIDTH-1:0] QCAP      = 36'sh4_0000_0000;
   localparam logic signed [Q_WIDTH-1:0] Q_ONE     = 36'sh0_0001_0000;
   localparam logic signed [Q_WIDTH-1:0] Q_W_MAX   = 36'sh0_7FFF_FFFF;
   localparam logic signed [Q_WIDTH-1:0] Q_W_MIN   = -36'sh0_8000_0000;
   localparam logic [CLIP_BITS-1:0]      CLIP_ONE  = 17'h1_0000;
   localparam logic [31:0]               WEIGHT_MAX = 32'h7FFF_FFFF;
   localparam logic [30:0]               DIST_MAX   = 31'h7FFF_FFFF;

   // saturate a wide quotient to a 32-bit signed weight
   function automatic logic [31:0] sat32(input logic signed [Q_WIDTH-1:0] v);
      logic [31:0] r;
      if (v > Q_W_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (v < Q_W_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== src/robust_barycentric_2d_core.sv =====
// Pipelined 2D barycentric weights with degeneracy and inside tests.
//
//  port group | dir | handshake          | beat contents
//  req_*      | in  | req_valid/stall    | point and three corners
//  rsp_*      | out | rsp_valid/stall    | three weights, flags, distance
//  csr_*      | in  | csr_valid/ready    | degenerate threshold
//
// One beat in per cycle while req_stall is low, through 58 register stages; the
// depth is set by the 34-step restoring divider for the weights plus the 17-step
// divider for renormalization.
// Each stage holds when the next is full and stalled, so bubbles collapse.
// Reset clears all stage valid bits and loads the threshold with 168.
// csr_ready is always high.
module robust_barycentric_2d_core #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COORD_WIDTH-1:0]    req_px,
   input  logic signed [COORD_WIDTH-1:0]    req_py,
   input  logic signed [COORD_WIDTH-1:0]    req_ax,
   input  logic signed [COORD_WIDTH-1:0]    req_ay,
   input  logic signed [COORD_WIDTH-1:0]    req_bx,
   input  logic signed [COORD_WIDTH-1:0]    req_by_coord,
   input  logic signed [COORD_WIDTH-1:0]    req_cx,
   input  logic signed [COORD_WIDTH-1:0]    req_cy,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_weight_a,
   output logic signed [31:0]               rsp_weight_b,
   output logic signed [31:0]               rsp_weight_c,
   output logic                             rsp_degenerate,
   output logic                             rsp_inside_res,
   output logic [30:0]                      rsp_outside_distance,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rbc_pkg::THR_WIDTH-1:0]    csr_degenerate_threshold
);
   import rbc_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int OW = PW + 1;
   localparam int MB = OW;
   localparam int CW = ((OW > THR_WIDTH + 1) ? OW : THR_WIDTH + 1) + 2;
   localparam int QB = QUOT_BITS;
   localparam int NB2 = CLIP_BITS;

   localparam int S_DIFF  = 0;
   localparam int S_PROD  = 1;
   localparam int S_ORI   = 2;
   localparam int S_SETUP = 3;
   localparam int S_Q     = S_SETUP + QB + 1;
   localparam int S_CLIP  = S_Q + 1;
   localparam int S_OUT   = S_CLIP + NB2 + 1;
   localparam int NS      = S_OUT + 1;

   typedef struct packed {
      logic [MB-1:0]         dmag;
      logic [2:0][MB-1:0]    rem;
      logic [2:0][QB-1:0]    low;
      logic [2:0]            neg;
      logic [2:0]            ovf;
      logic                  degen;
      logic                  in_tri;
   } div1_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]         sum;
      logic [2:0][SUM_BITS-1:0]    rem;
      logic [2:0][CLIP_BITS-1:0]   low;
      logic [2:0][31:0]            wsat;
      logic [30:0]                 excess;
      logic                        degen;
      logic                        in_tri;
   } div2_type;

   // ---------------- control: valid bits and bubble-collapsing enables
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   assign en[NS-1] = !v_ff[NS-1] || !rsp_stall;
   for (genvar k = 0; k < NS - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NS-1];

   // ---------------- threshold register
   logic [THR_WIDTH-1:0] thr_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_degenerate_threshold;
      end
   end

   // ---------------- stage: coordinate differences
   // 0 bx-ax, 1 cy-ay, 2 cx-ax, 3 by-ay, 4 cx-bx, 5 py-by, 6 px-bx, 7 cy-by,
   // 8 py-ay, 9 px-ax
   logic signed [DW-1:0] df_ff [10];

   always_ff @(posedge clock) begin
      if (en[S_DIFF]) begin
         df_ff[0] <= DW'(req_bx) - DW'(req_ax);
         df_ff[1] <= DW'(req_cy) - DW'(req_ay);
         df_ff[2] <= DW'(req_cx) - DW'(req_ax);
         df_ff[3] <= DW'(req_by_coord) - DW'(req_ay);
         df_ff[4] <= DW'(req_cx) - DW'(req_bx);
         df_ff[5] <= DW'(req_py) - DW'(req_by_coord);
         df_ff[6] <= DW'(req_px) - DW'(req_bx);
         df_ff[7] <= DW'(req_cy) - DW'(req_by_coord);
         df_ff[8] <= DW'(req_py) - DW'(req_ay);
         df_ff[9] <= DW'(req_px) - DW'(req_ax);
      end
   end

   // ---------------- stage: cross products
   logic signed [PW-1:0] pr_ff [8];

   always_ff @(posedge clock) begin
      if (en[S_PROD]) begin
         pr_ff[0] <= PW'(df_ff[0]) * PW'(df_ff[1]);
         pr_ff[1] <= PW'(df_ff[2]) * PW'(df_ff[3]);
         pr_ff[2] <= PW'(df_ff[4]) * PW'(df_ff[5]);
         pr_ff[3] <= PW'(df_ff[6]) * PW'(df_ff[7]);
         pr_ff[4] <= PW'(df_ff[2]) * PW'(df_ff[8]);
         pr_ff[5] <= PW'(df_ff[9]) * PW'(df_ff[1]);
         pr_ff[6] <= PW'(df_ff[0]) * PW'(df_ff[8]);
         pr_ff[7] <= PW'(df_ff[9]) * PW'(df_ff[3]);
      end
   end

   // ---------------- stage: determinants
   logic signed [OW-1:0] den_ff;
   logic signed [OW-1:0] num_ff [3];

   always_ff @(posedge clock) begin
      if (en[S_ORI]) begin
         den_ff    <= OW'(pr_ff[1]) - OW'(pr_ff[0]);
         num_ff[0] <= OW'(pr_ff[3]) - OW'(pr_ff[2]);
         num_ff[1] <= OW'(pr_ff[4]) - OW'(pr_ff[5]);
         num_ff[2] <= OW'(pr_ff[7]) - OW'(pr_ff[6]);
      end
   end

   // ---------------- stage: tests and divider setup
   div1_type dq_ff [QB+1];
   div1_type dq_in [QB+1];

   always_comb begin
      logic signed [CW-1:0] eps;
      logic signed [CW-1:0] dc;
      logic signed [CW-1:0] nc;
      logic signed [CW-1:0] absd;
      logic signed [CW-1:0] absn;
      logic                 ins;
      eps  = CW'($signed({1'b0, thr_ff}));
      dc   = CW'(den_ff);
      absd = (dc < 0) ? -dc : dc;
      ins  = 1'b1;
      dq_in[0] = '0;
      dq_in[0].dmag  = absd[MB-1:0];
      dq_in[0].degen = (absd < eps) || (den_ff == '0);
      for (int i = 0; i < 3; i++) begin
         nc   = CW'(num_ff[i]);
         absn = (nc < 0) ? -nc : nc;
         if (dc > 0) begin
            ins = ins && (nc >= -eps) && (nc <= dc + eps);
         end else begin
            ins = ins && (nc >= dc - eps) && (nc <= eps);
         end
         dq_in[0].rem[i] = MB'(absn[MB-1:0] >> (QB - FRAC_BITS));
         dq_in[0].ovf[i] = MB'(absn[MB-1:0] >> (QB - FRAC_BITS)) >= absd[MB-1:0];
         dq_in[0].low[i] = {absn[QB-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
         dq_in[0].neg[i] = (nc < 0) != (dc < 0);
      end
      dq_in[0].in_tri = ins;
   end

   always_ff @(posedge clock) begin
      if (en[S_SETUP]) begin
         dq_ff[0] <= dq_in[0];
      end
   end

   // ---------------- restoring divider, one quotient bit per stage
   for (genvar j = 0; j < QB; j++) begin : g_div1
      always_comb begin
         logic [MB:0] t;
         logic        ge;
         dq_in[j+1] = dq_ff[j];
         for (int i = 0; i < 3; i++) begin
            t  = {dq_ff[j].rem[i], dq_ff[j].low[i][QB-1]};
            ge = t >= {1'b0, dq_ff[j].dmag};
            dq_in[j+1].rem[i] = ge ? MB'(t - {1'b0, dq_ff[j].dmag}) : MB'(t);
            dq_in[j+1].low[i] = {dq_ff[j].low[i][QB-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_SETUP+1+j]) begin
            dq_ff[j+1] <= dq_in[j+1];
         end
      end
   end

   // ---------------- stage: signed capped quotients
   logic signed [Q_WIDTH-1:0] q_ff [3];
   logic                      qdeg_ff;
   logic                      qins_ff;

   always_ff @(posedge clock) begin
      if (en[S_Q]) begin
         for (int i = 0; i < 3; i++) begin
            if (dq_ff[QB].ovf[i]) begin
               q_ff[i] <= dq_ff[QB].neg[i] ? -QCAP : QCAP;
            end else if (dq_ff[QB].neg[i]) begin
               q_ff[i] <= -$signed({2'b00, dq_ff[QB].low[i]});
            end else begin
               q_ff[i] <= $signed({2'b00, dq_ff[QB].low[i]});
            end
         end
         qdeg_ff <= dq_ff[QB].degen;
         qins_ff <= dq_ff[QB].in_tri;
      end
   end

   // ---------------- stage: clip, excursion and renormalize setup
   div2_type e_ff [NB2+1];
   div2_type e_in [NB2+1];

   always_comb begin
      logic [CLIP_BITS-1:0]      c;
      logic [SUM_BITS-1:0]       s;
      logic signed [Q_WIDTH-1:0] m;
      logic signed [Q_WIDTH-1:0] lo;
      logic signed [Q_WIDTH-1:0] hi;
      s = '0;
      m = '0;
      e_in[0] = '0;
      for (int i = 0; i < 3; i++) begin
         if (q_ff[i] < 0) begin
            c = '0;
         end else if (q_ff[i] > Q_ONE) begin
            c = CLIP_ONE;
         end else begin
            c = q_ff[i][CLIP_BITS-1:0];
         end
         s  = s + SUM_BITS'(c);
         lo = -q_ff[i];
         hi = q_ff[i] - Q_ONE;
         if (lo > m) begin
            m = lo;
         end
         if (hi > m) begin
            m = hi;
         end
         e_in[0].rem[i]  = SUM_BITS'(c[CLIP_BITS-1:1]);
         e_in[0].low[i]  = {c[0], {FRAC_BITS{1'b0}}};
         e_in[0].wsat[i] = sat32(q_ff[i]);
      end
      e_in[0].sum    = (s == '0) ? SUM_BITS'(1) : s;
      e_in[0].excess = (m > Q_W_MAX) ? DIST_MAX : m[30:0];
      e_in[0].degen  = qdeg_ff;
      e_in[0].in_tri = qins_ff;
   end

   always_ff @(posedge clock) begin
      if (en[S_CLIP]) begin
         e_ff[0] <= e_in[0];
      end
   end

   // ---------------- renormalizing divider
   for (genvar j = 0; j < NB2; j++) begin : g_div2
      always_comb begin
         logic [SUM_BITS:0] t;
         logic              ge;
         e_in[j+1] = e_ff[j];
         for (int i = 0; i < 3; i++) begin
            t  = {e_ff[j].rem[i], e_ff[j].low[i][CLIP_BITS-1]};
            ge = t >= {1'b0, e_ff[j].sum};
            e_in[j+1].rem[i] = ge ? SUM_BITS'(t - {1'b0, e_ff[j].sum}) : SUM_BITS'(t);
            e_in[j+1].low[i] = {e_ff[j].low[i][CLIP_BITS-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_CLIP+1+j]) begin
            e_ff[j+1] <= e_in[j+1];
         end
      end
   end

   // ---------------- output register
   logic [2:0][31:0] w_ff;
   logic             deg_ff;
   logic             ins_ff;
   logic [30:0]      dist_ff;

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         for (int i = 0; i < 3; i++) begin
            if (e_ff[NB2].degen) begin
               w_ff[i] <= WEIGHT_MAX;
            end else if (e_ff[NB2].in_tri) begin
               w_ff[i] <= 32'(e_ff[NB2].low[i]);
            end else begin
               w_ff[i] <= e_ff[NB2].wsat[i];
            end
         end
         deg_ff  <= e_ff[NB2].degen;
         ins_ff  <= e_ff[NB2].in_tri;
         dist_ff <= e_ff[NB2].degen ? DIST_MAX : e_ff[NB2].excess;
      end
   end

   assign rsp_weight_a         = $signed(w_ff[0]);
   assign rsp_weight_b         = $signed(w_ff[1]);
   assign rsp_weight_c         = $signed(w_ff[2]);
   assign rsp_degenerate       = deg_ff;
   assign rsp_inside_res       = ins_ff;
   assign rsp_outside_distance = dist_ff;

   // ---------------- checks
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff))
      else $error("input stalled with a bubble in the pipeline");

   a_degen_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (w_ff[0] == WEIGHT_MAX && w_ff[1] == WEIGHT_MAX && w_ff[2] == WEIGHT_MAX
          && rsp_outside_distance == DIST_MAX))
      else $error("degenerate beat without saturated outputs");

   a_inside_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate && rsp_inside_res) |->
         (w_ff[0] <= 32'h1_0000 && w_ff[1] <= 32'h1_0000 && w_ff[2] <= 32'h1_0000))
      else $error("renormalized weight above one");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_SETUP] && !en[S_SETUP]) |=> v_ff[S_SETUP])
      else $error("stalled stage lost its beat");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 2D barycentric core: queued driver, checking monitor.
module tb_top;
   import rbc_pkg::*;

   localparam int CW      = 24;
   localparam int LATENCY = 58;

   typedef struct packed {
      logic signed [CW-1:0] px, py, ax, ay, bx, by, cx, cy;
   } query_type;

   typedef struct packed {
      logic [31:0] wa, wb, wc;
      logic        degen;
      logic        in_tri;
      logic [30:0] excess;
   } bary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_px = '0, req_py = '0, req_ax = '0, req_ay = '0;
   logic signed [CW-1:0] req_bx = '0, req_by_coord = '0, req_cx = '0, req_cy = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_weight_a, rsp_weight_b, rsp_weight_c;
   logic rsp_degenerate, rsp_inside_res;
   logic [30:0] rsp_outside_distance;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THR_WIDTH-1:0] csr_degenerate_threshold = '0;

   query_type query_q[$];
   bary_type  bary_q[$];
   logic [THR_WIDTH-1:0] eps_model = THR_RESET;
   int errors = 0;
   int n_beats = 0, n_rsp = 0, n_degen = 0, n_inside = 0;
   bit beat_taken = 1'b0;
   int burst_left = 0, gap_left = 0;
   int stall_mode = 0, stall_cnt = 0;

   always #5 clock = ~clock;

   robust_barycentric_2d_core #(.COORD_WIDTH(CW)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_px(req_px), .req_py(req_py), .req_ax(req_ax), .req_ay(req_ay),
      .req_bx(req_bx), .req_by_coord(req_by_coord), .req_cx(req_cx), .req_cy(req_cy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_weight_a(rsp_weight_a), .rsp_weight_b(rsp_weight_b),
      .rsp_weight_c(rsp_weight_c), .rsp_degenerate(rsp_degenerate),
      .rsp_inside_res(rsp_inside_res), .rsp_outside_distance(rsp_outside_distance),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_degenerate_threshold(csr_degenerate_threshold)
   );

   function automatic logic signed [127:0] cross_det(
      logic signed [127:0] ux, uy, vx, vy, wx, wy);
      return (vx - ux) * (wy - uy) - (wx - ux) * (vy - uy);
   endfunction

   // n*65536/d truncated toward zero, capped at magnitude 2^40
   function automatic logic signed [63:0] scaled_quot(logic signed [127:0] n,
                                                      logic signed [127:0] d);
      logic [127:0] a, b, q;
      a = (n < 0) ? -n : n;
      b = (d < 0) ? -d : d;
      q = (a << 16) / b;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return ((n < 0) != (d < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic bary_type predict_bary(query_type it, logic [THR_WIDTH-1:0] thr);
      logic signed [127:0] px, py, ax, ay, bx, by, cx, cy, den, e;
      logic signed [127:0] n[3];
      logic signed [63:0] q[3], c[3], excess, sum;
      logic [31:0] w[3];
      bary_type r;
      px = it.px; py = it.py; ax = it.ax; ay = it.ay;
      bx = it.bx; by = it.by; cx = it.cx; cy = it.cy;
      e = $signed({80'd0, thr});
      den = -cross_det(ax, ay, bx, by, cx, cy);
      n[0] = -cross_det(bx, by, cx, cy, px, py);
      n[1] = cross_det(ax, ay, cx, cy, px, py);
      n[2] = -cross_det(ax, ay, bx, by, px, py);
      r.degen = (((den < 0) ? -den : den) < e) || (den == 0);
      r.in_tri = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (den > 0) r.in_tri &= (n[i] >= -e) && (n[i] <= den + e);
         else r.in_tri &= (n[i] >= den - e) && (n[i] <= e);
      end
      if (r.degen) begin
         r.wa = WEIGHT_MAX; r.wb = WEIGHT_MAX; r.wc = WEIGHT_MAX; r.excess = DIST_MAX;
         return r;
      end
      excess = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         q[i] = scaled_quot(n[i], den);
         if (-q[i] > excess) excess = -q[i];
         if (q[i] - 65536 > excess) excess = q[i] - 65536;
         c[i] = (q[i] < 0) ? 64'sd0 : ((q[i] > 65536) ? 64'sd65536 : q[i]);
         sum += c[i];
      end
      r.excess = (excess > 64'sd2147483647) ? DIST_MAX : excess[30:0];
      if (sum == 0) sum = 1;
      for (int i = 0; i < 3; i++)
         w[i] = r.in_tri ? clamp32((c[i] * 65536) / sum) : clamp32(q[i]);
      r.wa = w[0]; r.wb = w[1]; r.wc = w[2];
      return r;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      return CW'($urandom());
   endfunction

   function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] base, int span);
      return base + $signed(CW'($urandom_range(2 * span, 0))) - CW'(span);
   endfunction

   // mostly compact triangles with a point nearby, sometimes wild coordinates
   function automatic query_type rand_query();
      query_type t;
      int span;
      logic signed [CW-1:0] ox, oy;
      case ($urandom_range(9, 0))
         0, 1: begin
            t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord()};
         end
         2: begin
            // nearly collinear corners
            ox = rand_coord(); oy = rand_coord();
            span = 1 << $urandom_range(16, 2);
            t.ax = ox; t.ay = oy;
            t.bx = ox + CW'(span); t.by = oy + CW'(span);
            t.cx = ox + CW'(2 * span) + CW'($urandom_range(2, 0)) - CW'(1);
            t.cy = oy + CW'(2 * span);
            t.px = near(ox, span); t.py = near(oy, span);
         end
         default: begin
            ox = rand_coord(); oy = rand_coord();
            span = 1 << $urandom_range(20, 1);
            t.ax = near(ox, span); t.ay = near(oy, span);
            t.bx = near(ox, span); t.by = near(oy, span);
            t.cx = near(ox, span); t.cy = near(oy, span);
            t.px = near(ox, span); t.py = near(oy, span);
            if ($urandom_range(3, 0) == 0) begin
               t.px = t.ax; t.py = t.ay;
            end
         end
      endcase
      return t;
   endfunction

   // accept side: beat bookkeeping and response checking
   always @(posedge clock) begin
      beat_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         bary_q.push_back(predict_bary(query_q.pop_front(), eps_model));
         beat_taken = 1'b1;
         n_beats++;
      end
      if (!reset && csr_valid && csr_ready) eps_model = csr_degenerate_threshold;
      if (!reset && rsp_valid && !rsp_stall) begin
         bary_type got, want;
         got = {rsp_weight_a, rsp_weight_b, rsp_weight_c, rsp_degenerate,
                rsp_inside_res, rsp_outside_distance};
         n_rsp++;
         if (bary_q.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, got);
            errors++;
         end else begin
            want = bary_q.pop_front();
            if (want.degen) n_degen++;
            if (want.in_tri) n_inside++;
            if (got.wa !== want.wa)
               $display("%0t: weight_a exp %h got %h", $time, want.wa, got.wa);
            if (got.wb !== want.wb)
               $display("%0t: weight_b exp %h got %h", $time, want.wb, got.wb);
            if (got.wc !== want.wc)
               $display("%0t: weight_c exp %h got %h", $time, want.wc, got.wc);
            if (got.degen !== want.degen)
               $display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
            if (got.in_tri !== want.in_tri)
               $display("%0t: inside exp %b got %b", $time, want.in_tri, got.in_tri);
            if (got.excess !== want.excess)
               $display("%0t: distance exp %h got %h", $time, want.excess, got.excess);
            if (got !== want) errors++;
         end
      end
   end

   // drive side: bursty sender, patterned receiver stall
   // the beat on the bus stays at the head of query_q until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !beat_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (query_q.size() > 0) begin
            req_valid <= 1'b1;
            {req_px, req_py, req_ax, req_ay, req_bx, req_by_coord, req_cx, req_cy} <=
               query_q[0];
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(30, 1);
               gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (stall_cnt == 0) begin
         stall_mode = $urandom_range(3, 0);
         stall_cnt = $urandom_range(300, 50);
      end
      stall_cnt--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(9, 0) < 3);
         2: rsp_stall <= (stall_cnt % 7) < 2;
         default: rsp_stall <= ($urandom_range(9, 0) < 8);
      endcase
   end

   task automatic drain();
      while (query_q.size() != 0 || bary_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_eps(logic [THR_WIDTH-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_degenerate_threshold <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_query(int px, py, ax, ay, bx, by, cx, cy);
      query_q.push_back({CW'(px), CW'(py), CW'(ax), CW'(ay),
                         CW'(bx), CW'(by), CW'(cx), CW'(cy)});
   endtask

   localparam logic signed [CW-1:0] MX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] ONE = 24'sd4096;

   initial begin
      logic [THR_WIDTH-1:0] eps_set[5];
      eps_set[0] = THR_RESET;
      eps_set[1] = '0;
      eps_set[2] = {THR_WIDTH{1'b1}};
      eps_set[3] = 48'd1 << 24;
      eps_set[4] = 48'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero area, unit triangle, vertex, edge, outside, clockwise, extremes
      add_query(0, 0, 0, 0, 0, 0, 0, 0);
      add_query(ONE / 4, ONE / 4, 0, 0, ONE, 0, 0, ONE);
      add_query(0, 0, 0, 0, ONE, 0, 0, ONE);
      add_query(ONE / 2, 0, 0, 0, ONE, 0, 0, ONE);
      add_query(ONE / 2, ONE / 2, 0, 0, ONE, 0, 0, ONE);
      add_query(3 * ONE, -2 * ONE, 0, 0, ONE, 0, 0, ONE);
      add_query(ONE / 4, ONE / 4, 0, 0, 0, ONE, ONE, 0);
      add_query(-ONE, -ONE, 0, 0, 0, ONE, ONE, 0);
      add_query(ONE, ONE, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
      add_query(0, 0, 0, 0, 1, 0, 0, 1);
      add_query(MX, MX, 0, 0, 1, 0, 0, 1);
      add_query(MX, MN, MN, MN, MX, MN, MN, MX);
      add_query(MN, MN, MN, MN, MX, MN, MN, MX);
      add_query(MX, MX, MX, MX, MN, MX, MX, MN);
      add_query(MX, MX, MN, MN, MX, MX, MN, MX);
      add_query(0, 0, MX, MX, MX, MX, MX, MX);
      add_query(-1, -1, 0, 0, ONE, 0, 0, ONE);
      add_query(ONE + 1, 0, 0, 0, ONE, 0, 0, ONE);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) write_eps(eps_set[ph]);
         for (int k = 0; k < 280; k++) query_q.push_back(rand_query());
         drain();
      end
      write_eps(THR_WIDTH'($urandom_range(65535, 0)));
      for (int k = 0; k < 300; k++) query_q.push_back(rand_query());
      drain();

      $display("Sent %0d query beats, checked %0d responses (%0d degenerate, %0d inside)",
               n_beats, n_rsp, n_degen, n_inside);
      $display("Covered six threshold settings including zero and full scale");
      if (errors == 0 && bary_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== robust_barycentric_2d_core.f =====
src/rbc_pkg.sv
src/robust_barycentric_2d_core.sv
tb/tb_top.sv
